// ===== hw/rtl/pcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_pkg - shared types and constants for the clamped PID controller
// Register indexes, datapath widths, configuration and command bundles.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int CfgIdxW = 3;
    localparam int DataW   = 16;
    localparam int ErrW    = 17;
    localparam int DiffW   = 18;
    localparam int MulAW   = 34;
    localparam int MulBW   = 18;
    localparam int ProdW   = MulAW + MulBW;
    localparam int PTermW  = 33;
    localparam int ItmpW   = 33;
    localparam int IprodW  = 50;
    localparam int IncW    = IprodW - 16;
    localparam int DTermW  = 34;
    localparam int AccW    = 48;
    localparam int SumW    = 50;

    localparam logic [CfgIdxW-1:0] REG_GAIN_P  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_GAIN_I  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_GAIN_D  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_PERIOD  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_OUT_MIN = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_OUT_MAX = 3'd5;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_P,
        MUL_I,
        MUL_IP,
        MUL_D
    } mul_op_t;

    typedef struct packed {
        logic signed [DataW-1:0] gain_p;
        logic signed [DataW-1:0] gain_i;
        logic signed [DataW-1:0] gain_d;
        logic        [DataW-1:0] sample_period;
        logic signed [DataW-1:0] out_min;
        logic signed [DataW-1:0] out_max;
    } cfg_t;

    typedef struct packed {
        logic    load;
        mul_op_t mul_op;
        logic    upd_acc;
        logic    calc_sum;
        logic    calc_drive;
        logic    push_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/pid_controller_clamped_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_clamped_top - fixed-point PID controller with output clamp
// Stream in target/sensed beats, stream out one clamped drive beat per sample.
// ----------------------------------------------------------------------------
// Each input beat carries a setpoint and a measurement; the error is
// sensed - target. The block forms gain_p*e, integrates gain_i*period*e into
// a saturating Q40.8 integrator (cleared at reset) and adds gain_d times the
// change in error. The sum is clamped to [out_min, out_max], the maximum test
// first, and truncated toward zero. A sample is accepted in idle, then the
// sequencer steps it through four passes of the single shared 34x18
// multiplier, the integrator, sum and clamp steps and the push into the
// output register; no new sample is accepted until that push is done. The
// output register holds a finished beat while the next sample is being worked;
// a stalled consumer stalls the sequencer only at the final push. Write
// configuration only while the block is idle; cfg_ready is always high and
// writes to an index beyond the register list are dropped.
// ----------------------------------------------------------------------------
module pid_controller_clamped_top
    import pcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // sample input
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // [15:0] target, [31:16] sensed
    // drive output
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,   // [15:0] drive
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [DataW-1:0]   cfg_data
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    // gain, period and limit registers
    pcc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: accept a beat in idle, then walk the datapath steps
    pcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic, integrator state and the output register
    pcc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .status    (status),
        .target    (s_tdata[15:0]),
        .sensed    (s_tdata[31:16]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .drive     (m_tdata)
    );

endmodule

// ===== hw/rtl/pcc_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_regs - configuration register file
// Six gain, period and limit registers written through a valid/ready channel.
// ----------------------------------------------------------------------------
module pcc_regs
    import pcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [DataW-1:0]   cfg_data,
    output cfg_t               cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p        <= 16'sd256;
            cfg_reg.gain_i        <= '0;
            cfg_reg.gain_d        <= '0;
            cfg_reg.sample_period <= 16'd655;
            cfg_reg.out_min       <= 16'sh8000;
            cfg_reg.out_max       <= 16'sh7fff;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GAIN_P:  cfg_reg.gain_p        <= cfg_data;
                REG_GAIN_I:  cfg_reg.gain_i        <= cfg_data;
                REG_GAIN_D:  cfg_reg.gain_d        <= cfg_data;
                REG_PERIOD:  cfg_reg.sample_period <= cfg_data;
                REG_OUT_MIN: cfg_reg.out_min       <= cfg_data;
                REG_OUT_MAX: cfg_reg.out_max       <= cfg_data;
                default:     ; // drop writes beyond the register list
            endcase
        end
    end

endmodule

// ===== hw/rtl/pcc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_ctrl - sequencer for the PID datapath
// Steps one sample through the shared multiplier, integrator, sum and clamp.
// ----------------------------------------------------------------------------
module pcc_ctrl
    import pcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_IP,
        ST_MUL_D,
        ST_ACC,
        ST_SUM,
        ST_CLAMP,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd            = '0;
        cmd.mul_op     = MUL_NONE;
        state_next     = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = s_tvalid;
                if (s_tvalid)
                    state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                cmd.mul_op = MUL_P;
                state_next = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                cmd.mul_op = MUL_I;
                state_next = ST_MUL_IP;
            end
            ST_MUL_IP:
            begin
                cmd.mul_op = MUL_IP;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                cmd.mul_op = MUL_D;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.upd_acc = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.calc_sum = 1'b1;
                state_next   = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.calc_drive = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the output register can take the beat
                cmd.push_out = status.out_free;
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/pcc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_dp - PID datapath
// Shared multiplier, saturating integrator, term sum, clamp and output beat.
// ----------------------------------------------------------------------------
module pcc_dp
    import pcc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  cmd_t                    cmd,
    output status_t                 status,
    input  logic signed [DataW-1:0] target,
    input  logic signed [DataW-1:0] sensed,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic        [DataW-1:0] drive
);

    logic signed [ErrW-1:0]   err_reg;
    logic signed [ErrW-1:0]   last_err_reg;
    logic signed [DiffW-1:0]  diff_reg;
    logic signed [PTermW-1:0] p_reg;
    logic signed [ItmpW-1:0]  itmp_reg;
    logic signed [IprodW-1:0] iprod_reg;
    logic signed [DTermW-1:0] d_reg;
    logic signed [AccW-1:0]   acc_reg;
    logic signed [SumW-1:0]   sum_reg;
    logic signed [DataW-1:0]  drive_reg;
    logic        [DataW-1:0]  out_data_reg;
    logic                     out_valid_reg;

    logic signed [ErrW-1:0]   err_next;
    logic signed [MulAW-1:0]  mul_a;
    logic signed [MulBW-1:0]  mul_b;
    logic signed [ProdW-1:0]  prod;
    logic signed [IncW-1:0]   inc;
    logic signed [AccW:0]     acc_wide;
    logic signed [AccW-1:0]   acc_next;
    logic signed [SumW-1:0]   lim_max;
    logic signed [SumW-1:0]   lim_min;
    logic signed [SumW-1:0]   sum_round;
    logic signed [DataW-1:0]  drive_next;

    assign err_next = ErrW'(sensed) - ErrW'(target);

    // operand select for the one shared multiplier
    always_comb
    begin
        case (cmd.mul_op)
            MUL_P:
            begin
                mul_a = MulAW'(err_reg);
                mul_b = MulBW'(cfg.gain_p);
            end
            MUL_I:
            begin
                mul_a = MulAW'(err_reg);
                mul_b = MulBW'(cfg.gain_i);
            end
            MUL_IP:
            begin
                mul_a = MulAW'(itmp_reg);
                mul_b = $signed({2'b00, cfg.sample_period});
            end
            MUL_D:
            begin
                mul_a = MulAW'(diff_reg);
                mul_b = MulBW'(cfg.gain_d);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // floor of the Q.24 increment to Q.8, then saturate the integrator
    assign inc      = iprod_reg[IprodW-1:16];
    assign acc_wide = (AccW+1)'(acc_reg) + (AccW+1)'(inc);

    always_comb
    begin
        if (acc_wide[AccW] != acc_wide[AccW-1])
            acc_next = acc_wide[AccW] ? {1'b1, {(AccW-1){1'b0}}}
                                      : {1'b0, {(AccW-1){1'b1}}};
        else
            acc_next = acc_wide[AccW-1:0];
    end

    // clamp, then truncate toward zero
    assign lim_max   = {{(SumW-DataW-8){cfg.out_max[DataW-1]}}, cfg.out_max, 8'h00};
    assign lim_min   = {{(SumW-DataW-8){cfg.out_min[DataW-1]}}, cfg.out_min, 8'h00};
    assign sum_round = sum_reg + (sum_reg[SumW-1] ? SumW'(255) : SumW'(0));

    always_comb
    begin
        if (sum_reg > lim_max)
            drive_next = cfg.out_max;
        else if (sum_reg < lim_min)
            drive_next = cfg.out_min;
        else
            drive_next = sum_round[DataW+7:8];
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign drive           = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_err_reg  <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                last_err_reg <= err_next;
            if (cmd.upd_acc)
                acc_reg <= acc_next;
            if (cmd.push_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            err_reg  <= err_next;
            diff_reg <= DiffW'(err_next) - DiffW'(last_err_reg);
        end
        case (cmd.mul_op)
            MUL_P:   p_reg     <= prod[PTermW-1:0];
            MUL_I:   itmp_reg  <= prod[ItmpW-1:0];
            MUL_IP:  iprod_reg <= prod[IprodW-1:0];
            MUL_D:   d_reg     <= prod[DTermW-1:0];
            default: ;
        endcase
        if (cmd.calc_sum)
            sum_reg <= SumW'(p_reg) + SumW'(acc_reg) + SumW'(d_reg);
        if (cmd.calc_drive)
            drive_reg <= drive_next;
        if (cmd.push_out)
            out_data_reg <= drive_reg;
    end

endmodule

// ===== tb/pcc_drive_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_drive_check - drive prediction and comparison for the clamped PID block
// Watches the configuration, sample and drive channels. Keeps its own copy of
// the registers, integrator and previous error, predicts one drive per sample
// and compares every drive beat against the oldest prediction.
// ----------------------------------------------------------------------------
module pcc_drive_check
    import pcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [31:0]        s_tdata,   // [15:0] target, [31:16] sensed
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [15:0]        m_tdata,   // [15:0] drive
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [DataW-1:0]   cfg_data,
    output int                 mismatches,
    output int                 drives_due,
    output int                 drives_checked,
    output int                 clamped_high,
    output int                 clamped_low
);

    localparam longint IntegHi   = 64'sd140737488355327;
    localparam longint IntegLo   = -IntegHi - 1;

    typedef struct {
        logic [DataW-1:0] target;
        logic [DataW-1:0] sensed;
        logic [DataW-1:0] drive;
    } drive_beat_t;

    cfg_t        regs;
    longint      integ;
    longint      prev_err;
    drive_beat_t drive_fifo[$];
    int          n_bad     = 0;
    int          n_checked = 0;
    int          n_high    = 0;
    int          n_low     = 0;

    // Advance the controller by one sample and return the drive it must produce.
    function automatic logic [DataW-1:0] next_drive(input logic [DataW-1:0] tgt_bits,
                                                    input logic [DataW-1:0] sns_bits);
        longint err;
        longint p_term;
        longint inc;
        longint acc;
        longint d_term;
        longint sum;
        longint lim_hi;
        longint lim_lo;
        longint drive;
        err    = longint'($signed(sns_bits)) - longint'($signed(tgt_bits));
        p_term = longint'($signed(regs.gain_p)) * err;
        // arithmetic shift floors the Q.24 increment down to Q.8
        inc    = (longint'($signed(regs.gain_i)) * longint'({48'd0, regs.sample_period})
                  * err) >>> 16;
        acc    = integ + inc;
        if (acc > IntegHi)
            acc = IntegHi;
        else if (acc < IntegLo)
            acc = IntegLo;
        integ  = acc;
        d_term = longint'($signed(regs.gain_d)) * (err - prev_err);
        sum    = p_term + acc + d_term;
        lim_hi = longint'($signed(regs.out_max)) * 256;
        lim_lo = longint'($signed(regs.out_min)) * 256;
        if (sum > lim_hi)
        begin
            drive = longint'($signed(regs.out_max));
            n_high++;
        end
        else if (sum < lim_lo)
        begin
            drive = longint'($signed(regs.out_min));
            n_low++;
        end
        else if (sum >= 0)
            drive = sum >>> 8;
        else
            drive = -((-sum) >>> 8);
        prev_err = err;
        return drive[DataW-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        drive_beat_t beat;
        if (!rst_n)
        begin
            regs.gain_p        = 16'sd256;
            regs.gain_i        = 16'sd0;
            regs.gain_d        = 16'sd0;
            regs.sample_period = 16'd655;
            regs.out_min       = -16'sd32768;
            regs.out_max       = 16'sd32767;
            integ              = 0;
            prev_err           = 0;
            drive_fifo.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GAIN_P:  regs.gain_p        = cfg_data;
                    REG_GAIN_I:  regs.gain_i        = cfg_data;
                    REG_GAIN_D:  regs.gain_d        = cfg_data;
                    REG_PERIOD:  regs.sample_period = cfg_data;
                    REG_OUT_MIN: regs.out_min       = cfg_data;
                    REG_OUT_MAX: regs.out_max       = cfg_data;
                    default:     ;
                endcase
            end
            // retire the oldest prediction before queuing a new one
            if (m_tvalid && m_tready)
            begin
                if (drive_fifo.size() == 0)
                begin
                    n_bad++;
                    $display("%0t: drive beat %0d arrived with no sample outstanding",
                             $time, $signed(m_tdata));
                end
                else
                begin
                    beat = drive_fifo.pop_front();
                    n_checked++;
                    if (m_tdata !== beat.drive)
                    begin
                        n_bad++;
                        $display({"%0t: drive mismatch (target %0d, sensed %0d): ",
                                  "expected %0d, got %0d"},
                                 $time, $signed(beat.target), $signed(beat.sensed),
                                 $signed(beat.drive), $signed(m_tdata));
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                beat.target = s_tdata[15:0];
                beat.sensed = s_tdata[31:16];
                beat.drive  = next_drive(beat.target, beat.sensed);
                drive_fifo.push_back(beat);
            end
        end
        mismatches     <= n_bad;
        drives_due     <= drive_fifo.size();
        drives_checked <= n_checked;
        clamped_high   <= n_high;
        clamped_low    <= n_low;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - stimulus and verdict for the clamped PID controller
// Resets the block, writes register settings between phases, streams sample
// beats with random gaps against a randomly stalling consumer, and leaves all
// checking to pcc_drive_check.
// ----------------------------------------------------------------------------
module tb_top;
    import pcc_pkg::*;

    // indexes past the end of the register list; writes there must be dropped
    localparam logic [CfgIdxW-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_SPARE_B = 3'd7;

    localparam int     ClkHalf       = 5;
    localparam int     ResetCycles   = 9;
    localparam int     RandomItems   = 1400;
    // largest-increment samples that push the integrator far from zero
    localparam int     RampItems     = 24;
    localparam int     SettleCycles  = 40;
    localparam longint CycleLimit    = 4000000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [15:0]        m_tdata;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = REG_GAIN_P;
    logic [DataW-1:0]   cfg_data  = '0;

    int     mismatches;
    int     drives_due;
    int     drives_checked;
    int     clamped_high;
    int     clamped_low;

    bit     quiet_in      = 1'b0;   // no gaps between sample beats
    bit     quiet_out     = 1'b0;   // consumer never stalls
    int     ready_hold    = 0;
    int     samples_sent  = 0;
    int     cfg_writes    = 0;
    int     settings_used = 0;
    longint cycle_count   = 0;

    always #(ClkHalf) clk = ~clk;

    pid_controller_clamped_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pcc_drive_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .drives_due     (drives_due),
        .drives_checked (drives_checked),
        .clamped_high   (clamped_high),
        .clamped_low    (clamped_low)
    );

    // Gap length in cycles: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Setpoint or measurement: corners, full range, or a small value near zero.
    function automatic logic [DataW-1:0] pick_level(input bit wide);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        if (wide || r < 30)
            return DataW'($urandom);
        return DataW'($urandom_range(0, 1200)) - 16'd600;
    endfunction

    // Q8.8 gain: extremes, full range, or within +/-4.0.
    function automatic logic [DataW-1:0] pick_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h0000;
                default: return 16'h0100;
            endcase
        end
        if (r < 35)
            return DataW'($urandom);
        return DataW'($urandom_range(0, 2048)) - 16'd1024;
    endfunction

    // Consumer: hold tready low for random stretches, advance otherwise.
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            m_tready   <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else if (!quiet_out && $urandom_range(0, 99) < 25)
        begin
            m_tready   <= 1'b0;
            ready_hold <= idle_len();
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog: stop a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("%0t: run stopped after %0d cycles, %0d drive beats still due",
                     $time, cycle_count, drives_due);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Present one sample beat and hold it until accepted. tvalid stays high
    // into the next beat when there is no gap, so it is never dropped and
    // raised within one step.
    task automatic send_sample(input logic [DataW-1:0] tgt, input logic [DataW-1:0] sns);
        int gap;
        gap = quiet_in ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sns, tgt};
        do
            @(posedge clk);
        while (!s_tready);
        samples_sent++;
    endtask

    task automatic end_samples();
        s_tvalid <= 1'b0;
    endtask

    // Wait until every predicted drive beat has been seen.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (drives_due != 0);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_writes++;
    endtask

    // Drain the block, then write the full register set; optionally poke the
    // unmapped indexes afterwards, which must leave the set untouched.
    task automatic apply_setting(input logic [DataW-1:0] gp, input logic [DataW-1:0] gi,
                                 input logic [DataW-1:0] gd, input logic [DataW-1:0] per,
                                 input logic [DataW-1:0] lo, input logic [DataW-1:0] hi,
                                 input bit spare);
        end_samples();
        wait_drained();
        write_reg(REG_GAIN_P,  gp);
        write_reg(REG_GAIN_I,  gi);
        write_reg(REG_GAIN_D,  gd);
        write_reg(REG_PERIOD,  per);
        write_reg(REG_OUT_MIN, lo);
        write_reg(REG_OUT_MAX, hi);
        if (spare)
        begin
            write_reg(REG_SPARE_A, DataW'($urandom));
            write_reg(REG_SPARE_B, DataW'($urandom));
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        int               random_items;
        int               n;
        bit               paired;
        logic [DataW-1:0] gp;
        logic [DataW-1:0] gi;
        logic [DataW-1:0] gd;
        logic [DataW-1:0] per;
        logic [DataW-1:0] lo;
        logic [DataW-1:0] hi;
        logic [DataW-1:0] swap;
        logic [DataW-1:0] tgt;
        logic [DataW-1:0] sns;

        random_items = 0;
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part -------------------------------------------------
        // Reset values: unity P gain, full limits. Zero error, both clamps
        // from the widest error, and two plain in-range errors.
        send_sample(16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'd5, -16'sd7);
        send_sample(-16'sd300, 16'd1000);

        // Half gain: negative fractions truncate toward zero, not down.
        apply_setting(16'd128, 16'd0, 16'd0, 16'd0, 16'h8000, 16'h7FFF, 1'b0);
        send_sample(16'd0, -16'sd3);
        send_sample(16'd0, 16'd3);
        send_sample(-16'sd1, -16'sd2);

        // Pure integrator at unity gain and full period: the increment floors,
        // so -1 then +1 leaves a residue of one LSB below zero.
        apply_setting(16'd0, 16'd256, 16'd0, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b0);
        send_sample(16'd1, 16'd0);
        send_sample(16'd0, 16'd1);

        // Extreme gains and a narrow window; the mirrored pair steps the integrator
        // out and back, the zero error hits the derivative hard.
        apply_setting(16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, -16'sd100, 16'd100, 1'b0);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'd10, 16'd10);
        send_sample(16'd0, 16'd0);

        // Crossed limits: the maximum test wins whenever the sum is above it.
        apply_setting(16'd256, 16'd0, 16'd0, 16'd655, 16'h7FFF, 16'h8000, 1'b0);
        send_sample(16'h7FFF, 16'hFFFF);
        send_sample(16'd0, 16'hFFFF);
        apply_setting(16'd256, 16'd0, 16'd0, 16'd655, 16'd5, -16'sd5, 1'b0);
        send_sample(16'd0, 16'd3);
        send_sample(16'd0, -16'sd10);

        // Writes to unmapped indexes must not disturb the register set.
        apply_setting(16'd256, 16'd0, 16'd0, 16'd655, 16'h8000, 16'h7FFF, 1'b1);
        send_sample(16'd100, 16'd200);

        // --- random part ---------------------------------------------------
        // Paired phases take any gains but send each sample followed by its
        // mirror image, so the integrator steps out and back and stays near
        // zero. Drift phases keep the integral gain tiny and let it wander.
        while (random_items < RandomItems)
        begin
            paired   = ($urandom_range(0, 9) < 6);
            quiet_in = ($urandom_range(0, 4) == 0);
            quiet_out <= quiet_in;
            gp = pick_gain();
            gd = pick_gain();
            if (paired)
            begin
                gi = pick_gain();
                case ($urandom_range(0, 6))
                    0:       per = 16'h0000;
                    1:       per = 16'hFFFF;
                    default: per = DataW'($urandom);
                endcase
            end
            else
            begin
                gi  = DataW'($urandom_range(0, 64)) - 16'd32;
                per = DataW'($urandom_range(0, 2048));
            end
            n = $urandom_range(0, 99);
            if (n < 40)
            begin
                lo = 16'h8000;
                hi = 16'h7FFF;
            end
            else if (n < 82)
            begin
                lo = DataW'($urandom);
                hi = DataW'($urandom);
                // sorted window, or deliberately crossed
                if (($signed(lo) > $signed(hi)) == (n < 70))
                begin
                    swap = lo;
                    lo   = hi;
                    hi   = swap;
                end
            end
            else if (n < 92)
            begin
                lo = DataW'($urandom);
                hi = lo;
            end
            else
            begin
                lo = 16'h7FFF;
                hi = 16'h8000;
            end
            apply_setting(gp, gi, gd, per, lo, hi, ($urandom_range(0, 4) == 0));

            repeat ($urandom_range(20, 60))
            begin
                if (paired)
                begin
                    n   = $urandom_range(0, 1);
                    tgt = pick_level(n[0]);
                    sns = pick_level(n[0]);
                    send_sample(tgt, sns);
                    send_sample(sns, tgt);
                    random_items += 2;
                end
                else
                begin
                    send_sample(pick_level(1'b0), pick_level(1'b0));
                    random_items++;
                end
            end
        end

        // --- large integrator steps -----------------------------------------
        // Drive the largest positive increment for a while so the integrator
        // runs far above the output range, then step it back a little.
        quiet_in = 1'b1;
        quiet_out <= 1'b1;
        apply_setting(16'd256, 16'h7FFF, 16'd0, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b0);
        repeat (RampItems) send_sample(16'h8000, 16'h7FFF);
        repeat (8) send_sample(16'h7FFF, 16'h8000);

        end_samples();
        wait_drained();
        repeat (SettleCycles) @(posedge clk);

        $display("Covered %0d samples over %0d register settings (%0d register writes).",
                 samples_sent, settings_used, cfg_writes);
        $display("Checked %0d drive beats: %0d clamped high, %0d clamped low.",
                 drives_checked, clamped_high, clamped_low);
        if (mismatches == 0 && drives_due == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
